@@ src/rcd_pkg.sv @@
// ----------------------------------------------------------------------------
// rcd_pkg
// Shared types, constants and helpers for the radix conversion block.
// ----------------------------------------------------------------------------
package rcd_pkg;

  localparam int VALUE_BITS_DEFAULT = 31;
  localparam int BASE_W             = 5;
  localparam int DIGIT_W            = 4;
  localparam int CHAR_W             = 7;

  localparam logic [BASE_W-1:0] BASE_RESET = 5'd10;
  localparam logic [BASE_W-1:0] BASE_MIN   = 5'd2;
  localparam logic [BASE_W-1:0] BASE_MAX   = 5'd16;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_ALPHA = 7'd55;  // 'A' - 10

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_RD,
    S_OUT
  } state_t;

  // Requests from the sequencer to the divider.
  typedef struct packed {
    logic load;   // take a new dividend and start dividing it
    logic start;  // divide the held quotient once more
  } div_ctrl_t;

  // Status from the divider back to the sequencer.
  typedef struct packed {
    logic done;       // remainder and quotient are final this cycle
    logic quot_zero;  // held quotient is zero
  } div_stat_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] ext;
    ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d < 4'd10) begin
      return CHAR_ZERO + ext;
    end else begin
      return CHAR_ALPHA + ext;
    end
  endfunction

endpackage

@@ src/rcd_ram.sv @@
// ----------------------------------------------------------------------------
// rcd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rcd_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 31
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/rcd_divider.sv @@
// ----------------------------------------------------------------------------
// rcd_divider
// Bit-serial restoring divider by a small base; keeps the quotient in place.
// ----------------------------------------------------------------------------
module rcd_divider #(
  parameter int VALUE_BITS = rcd_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rcd_pkg::div_ctrl_t            ctrl,
  input  logic [VALUE_BITS-1:0]         dividend,
  input  logic [rcd_pkg::BASE_W-1:0]    base,
  output rcd_pkg::div_stat_t            stat,
  output logic [rcd_pkg::DIGIT_W-1:0]   remainder
);

  import rcd_pkg::*;

  localparam int CNT_W = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0] work;
  logic [DIGIT_W-1:0]    rem;
  logic [CNT_W-1:0]      cnt;
  logic                  running;
  logic                  done;

  logic [BASE_W-1:0]     shifted;
  logic [BASE_W-1:0]     diff;
  logic                  ge;

  // The partial remainder stays below the base, so one more bit fits in five.
  assign shifted = {rem, work[VALUE_BITS-1]};
  assign ge      = (shifted >= base);
  assign diff    = shifted - base;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else if (ctrl.load || ctrl.start) begin
      running <= 1'b1;
      done    <= 1'b0;
      cnt     <= CNT_W'(VALUE_BITS - 1);
    end else if (running) begin
      if (cnt == '0) begin
        running <= 1'b0;
        done    <= 1'b1;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      work <= dividend;
      rem  <= '0;
    end else if (ctrl.start) begin
      rem <= '0;
    end else if (running) begin
      work <= {work[VALUE_BITS-2:0], ge};
      rem  <= ge ? diff[DIGIT_W-1:0] : shifted[DIGIT_W-1:0];
    end
  end

  assign stat.done      = done;
  assign stat.quot_zero = (work == '0);
  assign remainder      = rem;

endmodule

@@ src/radix_conversion_to_digits_top.sv @@
// Each digit comes from one pass of the bit-serial divider, which keeps the
// quotient for the next pass; once the quotient is zero, every digit is read
// back from the RAM in S_RD and emitted in S_OUT, most significant first.
// A new request is taken only from idle; busy stays high until the last digit.
// The shared bit-serial divider sets the rate. No result stalls.
// Reset (synchronous, active high) clears the sequencer and sets base to 10.
// ----------------------------------------------------------------------------
// radix_conversion_to_digits_top
// Converts an unsigned integer to ASCII digits in a programmable base.
// ----------------------------------------------------------------------------
module radix_conversion_to_digits_top #(
  parameter int VALUE_BITS = rcd_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [rcd_pkg::BASE_W-1:0]   cfg_data,
  input  logic                         start,
  output logic                         busy,
  input  logic [VALUE_BITS-1:0]        value,
  output logic                         digit_valid,
  output logic [rcd_pkg::CHAR_W-1:0]   digit_char,
  output logic                         last
);

  import rcd_pkg::*;

  localparam int ADDR_W  = $clog2(VALUE_BITS);
  localparam int COUNT_W = $clog2(VALUE_BITS + 1);

  state_t               state;
  state_t               state_next;
  logic [BASE_W-1:0]    base;
  logic [COUNT_W-1:0]   count;
  logic [ADDR_W-1:0]    pos;

  div_ctrl_t            div_ctrl;
  div_stat_t            div_stat;
  logic [DIGIT_W-1:0]   remainder;
  logic [DIGIT_W-1:0]   rd_digit;

  logic                 mem_we;
  logic                 mem_re;
  logic                 count_clr;
  logic                 pos_load;
  logic                 pos_dec;
  logic                 emit;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = !busy;

  // Base register; writes outside two to sixteen are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      base <= BASE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_data >= BASE_MIN && cfg_data <= BASE_MAX) begin
        base <= cfg_data;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done && div_stat.quot_zero) begin
          state_next = S_RD;
        end
      end
      S_RD: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (pos == '0) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    div_ctrl  = '0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    count_clr = 1'b0;
    pos_load  = 1'b0;
    pos_dec   = 1'b0;
    emit      = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          div_ctrl.load = 1'b1;
          count_clr     = 1'b1;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          mem_we = 1'b1;
          if (div_stat.quot_zero) begin
            pos_load = 1'b1;
          end else begin
            div_ctrl.start = 1'b1;
          end
        end
      end
      S_RD: begin
        mem_re = 1'b1;
      end
      S_OUT: begin
        emit    = 1'b1;
        pos_dec = (pos != '0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      digit_valid <= 1'b0;
    end else begin
      state       <= state_next;
      digit_valid <= emit;
      if (count_clr) begin
        count <= '0;
      end else if (mem_we) begin
        count <= count + 1'b1;
      end
    end
  end

  // The last digit written is the most significant one; emission walks down.
  always_ff @(posedge clk) begin
    if (pos_load) begin
      pos <= count[ADDR_W-1:0];
    end else if (pos_dec) begin
      pos <= pos - 1'b1;
    end
    if (emit) begin
      digit_char <= digit_to_ascii(rd_digit);
      last       <= (pos == '0);
    end
  end

  rcd_divider #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (div_ctrl),
    .dividend  (value),
    .base      (base),
    .stat      (div_stat),
    .remainder (remainder)
  );

  rcd_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (VALUE_BITS)
  ) u_digits (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count[ADDR_W-1:0]),
    .wdata (remainder),
    .re    (mem_re),
    .raddr (pos),
    .rdata (rd_digit)
  );

endmodule

@@ src/rcd_checker.sv @@
// ----------------------------------------------------------------------------
// rcd_checker
// Port-level checks for the radix conversion block, bound to the top level.
// ----------------------------------------------------------------------------
module rcd_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       digit_valid,
  input logic [rcd_pkg::CHAR_W-1:0] digit_char,
  input logic                       last
);

  // Every emitted character is a hex digit in upper case.
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    digit_valid |-> ((digit_char >= 7'd48 && digit_char <= 7'd57) ||
                     (digit_char >= 7'd65 && digit_char <= 7'd70)))
    else $error("digit character out of range");

  // While more digits follow, the block must still report busy.
  a_busy_mid_run: assert property (@(posedge clk) disable iff (rst)
    (digit_valid && !last) |-> busy)
    else $error("idle before the last digit");

  // An accepted request makes the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // Two digit strobes never come back to back.
  a_digit_gap: assert property (@(posedge clk) disable iff (rst)
    digit_valid |=> !digit_valid)
    else $error("back-to-back digit strobes");

  // Reset leaves the block idle with no result pending.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!busy && !digit_valid))
    else $error("block not idle after reset");

endmodule

bind radix_conversion_to_digits_top rcd_checker u_rcd_checker (.*);

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the radix conversion block against a digit predictor. Values go in
// through the start/busy port and base settings through the config channel,
// and every digit strobe is compared with the oldest predicted digit.
// ----------------------------------------------------------------------------
module tb;

  localparam int VB = rcd_pkg::VALUE_BITS_DEFAULT;
  localparam logic [8*16-1:0] GLYPHS = "0123456789ABCDEF";

  typedef struct packed {
    logic [rcd_pkg::CHAR_W-1:0] ch;
    logic                       last;
  } digit_t;

  logic                        clk;
  logic                        rst;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [rcd_pkg::BASE_W-1:0]  cfg_data;
  logic                        start;
  logic                        busy;
  logic [VB-1:0]               value;
  logic                        digit_valid;
  logic [rcd_pkg::CHAR_W-1:0]  digit_char;
  logic                        last;

  logic [rcd_pkg::BASE_W-1:0]  radix;
  digit_t                      expected_digits[$];
  int                          failures = 0;

  radix_conversion_to_digits_top #(.VALUE_BITS(VB)) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .start       (start),
    .busy        (busy),
    .value       (value),
    .digit_valid (digit_valid),
    .digit_char  (digit_char),
    .last        (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  // Splits a value into remainders of the current radix and queues the
  // characters most significant first.
  function automatic void predict_digits(input logic [VB-1:0] v);
    logic [3:0]    rems[VB];
    logic [VB-1:0] rest;
    int            n;
    digit_t        d;
    rest = v;
    n = 0;
    do begin
      rems[n] = 4'(rest % radix);
      n = n + 1;
      rest = rest / radix;
    end while (rest != 0);
    for (int k = n - 1; k >= 0; k--) begin
      d.ch = GLYPHS[8*(15 - int'(rems[k])) +: 7];
      d.last = (k == 0);
      expected_digits = {expected_digits, d};
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 6);
    end else begin
      return $urandom_range(30, 1200);
    end
  endfunction

  function automatic logic [VB-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: begin
        return '0;
      end
      1: begin
        return '1;
      end
      2: begin
        return VB'($urandom_range(1, 40));
      end
      default: begin
        return VB'($urandom() >> $urandom_range(0, 31));
      end
    endcase
  endfunction

  // Entered and left just after a falling edge. With a zero gap start stays
  // high so that the next request follows without a dead cycle.
  task automatic send_value(input logic [VB-1:0] v, input int gap);
    start <= 1'b1;
    value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_digits(v);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      value <= VB'($urandom());
      repeat (gap) @(negedge clk);
    end
  endtask

  // Lowers start and waits until every predicted digit has come out.
  task automatic settle();
    start <= 1'b0;
    @(negedge clk);
    while (expected_digits.size() != 0 || busy) @(negedge clk);
  endtask

  task automatic write_base(input logic [rcd_pkg::BASE_W-1:0] b);
    settle();
    repeat ($urandom_range(0, 3)) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= b;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (b >= rcd_pkg::BASE_MIN && b <= rcd_pkg::BASE_MAX) begin
      radix = b;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_data  <= rcd_pkg::BASE_W'($urandom());
  endtask

  task automatic test_default_base();
    send_value('0, 0);
    send_value(VB'(1), 1);
    send_value(VB'(9), 0);
    send_value(VB'(10), 3);
    send_value(VB'(99), 0);
    send_value('1, 0);
    send_value(VB'(1000000000), 2);
  endtask

  task automatic test_binary_extremes();
    write_base(rcd_pkg::BASE_MIN);
    send_value('0, 0);
    send_value(VB'(1), 0);
    send_value('1, 1);
    send_value(VB'(1) << (VB - 1), 0);
  endtask

  task automatic test_hex_extremes();
    write_base(rcd_pkg::BASE_MAX);
    send_value(VB'(15), 0);
    send_value(VB'(16), 0);
    send_value('1, 2);
    send_value('0, 0);
    send_value(VB'(32'h2AAA_AAAA), 1);
  endtask

  // Out-of-range writes must leave base sixteen in place.
  task automatic test_rejected_bases();
    write_base(5'd0);
    send_value(VB'(255), 1);
    write_base(5'd1);
    send_value(VB'(255), 1);
    write_base(5'd17);
    send_value(VB'(4095), 1);
    write_base(5'd31);
    send_value(VB'(4095), 1);
    write_base(5'd3);
    send_value('1, 1);
  endtask

  task automatic test_random_traffic();
    logic [rcd_pkg::BASE_W-1:0] b;
    for (int phase = 0; phase < 7; phase++) begin
      if (phase == 0) begin
        b = rcd_pkg::BASE_MIN;
      end else if (phase == 1) begin
        b = rcd_pkg::BASE_MAX;
      end else if ($urandom_range(0, 4) == 0) begin
        b = rcd_pkg::BASE_W'($urandom());
      end else begin
        b = rcd_pkg::BASE_W'($urandom_range(2, 16));
      end
      write_base(b);
      for (int i = 0; i < 20; i++) begin
        send_value(pick_value(), pick_gap());
        if ($urandom_range(0, 9) == 0) begin
          settle();
        end
      end
    end
  endtask

  always @(posedge clk) begin
    digit_t want;
    if (!rst && digit_valid) begin
      if (expected_digits.size() == 0) begin
        $error("digit_char: expected none, got %0d", digit_char);
        failures++;
      end else begin
        want = expected_digits.pop_front();
        if (digit_char !== want.ch) begin
          $error("digit_char: expected %0d, got %0d", want.ch, digit_char);
          failures++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last);
          failures++;
        end
      end
    end
  end

  initial begin
    radix     = rcd_pkg::BASE_RESET;
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    start     = 1'b0;
    value     = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_default_base();
    test_binary_extremes();
    test_hex_extremes();
    test_rejected_bases();
    test_random_traffic();

    settle();
    repeat (50) @(posedge clk);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/rcd_pkg.sv
src/rcd_ram.sv
src/rcd_divider.sv
src/radix_conversion_to_digits_top.sv
src/rcd_checker.sv
test/tb.sv
